FILE: sv/bht_pkg.sv
// Shared constants, codes and types of the branch history table predictor.
// Depends on nothing; the instruction interface, the update module and the predictor import it.
package bht_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int INDEX_SHIFT   = 3;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CTR_W         = 2;
    localparam int ADDR_W        = 32;

    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_ONE_BIT = 2'd1;
    localparam logic [1:0] MODE_TWO_BIT = 2'd2;

    localparam logic [1:0] KIND_OTHER  = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_JUMP   = 2'd2;

    localparam logic [CTR_W-1:0] CTR_STRONG_NOT = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_NOT   = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_STRONG     = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CTR_W-1:0] ctr_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] kind;
        logic       taken;
        logic       hit_valid;
        ctr_t       ctr;
    } bht_upd_in_t;

    typedef struct packed {
        logic active;
        logic correct;
        ctr_t ctr_next;
    } bht_upd_out_t;

endpackage

FILE: sv/bht_instr_if.sv
// Channel interface for resolved instructions entering the predictor.
// Depends on bht_pkg for the address width.
interface bht_instr_if
    import bht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        instr_kind;
    logic [ADDR_W-1:0] instr_pc;
    logic [ADDR_W-1:0] target_addr;
    logic [ADDR_W-1:0] next_pc;

    modport source (
        output valid, instr_kind, instr_pc, target_addr, next_pc,
        input  ready
    );

    modport sink (
        input  valid, instr_kind, instr_pc, target_addr, next_pc,
        output ready
    );
endinterface

FILE: sv/bht_result_if.sv
// Channel interface for the prediction results leaving the predictor.
// Depends on nothing outside itself.
interface bht_result_if;
    logic valid;
    logic ready;
    logic pred_ok;

    modport source (
        output valid, pred_ok,
        input  ready
    );

    modport sink (
        input  valid, pred_ok,
        output ready
    );
endinterface

FILE: sv/bht_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; a read of an address written at the same edge returns old data.
module bht_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/bht_update.sv
// Counter update and prediction check for one table entry.
// Depends on bht_pkg for the mode, kind and counter codes and the update structs.
module bht_update
    import bht_pkg::*;
(
    input  bht_upd_in_t  upd_in,
    output bht_upd_out_t upd_out
);

    logic right;
    ctr_t two_bit_next;

    always_comb
    begin
        case (upd_in.ctr)
            CTR_STRONG_NOT: two_bit_next = upd_in.taken ? CTR_WEAK_NOT : CTR_STRONG_NOT;
            CTR_WEAK_NOT:   two_bit_next = upd_in.taken ? CTR_STRONG : CTR_STRONG_NOT;
            CTR_WEAK_TAKEN: two_bit_next = upd_in.taken ? CTR_STRONG : CTR_STRONG_NOT;
            default:        two_bit_next = upd_in.taken ? CTR_STRONG : CTR_WEAK_TAKEN;
        endcase
    end

    always_comb
    begin
        if (upd_in.mode == MODE_TWO_BIT)
        begin
            right = (upd_in.ctr[CTR_W-1] == upd_in.taken);
        end
        else
        begin
            right = (upd_in.ctr == {{(CTR_W-1){1'b0}}, upd_in.taken});
        end
    end

    always_comb
    begin
        upd_out.active = ((upd_in.mode == MODE_ONE_BIT) || (upd_in.mode == MODE_TWO_BIT))
                      && ((upd_in.kind == KIND_BRANCH) || (upd_in.kind == KIND_JUMP));

        if (!upd_in.hit_valid)
        begin
            upd_out.correct = 1'b0;
        end
        else if (upd_in.kind == KIND_JUMP)
        begin
            upd_out.correct = 1'b1;
        end
        else
        begin
            upd_out.correct = right;
        end

        if (upd_in.mode == MODE_ONE_BIT)
        begin
            upd_out.ctr_next = {{(CTR_W-1){1'b0}}, upd_in.taken};
        end
        else
        begin
            upd_out.ctr_next = two_bit_next;
        end
    end

endmodule

FILE: sv/branch_history_table_predictor.sv
// The predictor takes one resolved instruction per cycle unless the result channel
// stalls, and returns one result per instruction after its s1 and output registers.
// The counters live in a 128-entry RAM, read when an instruction is taken and written
// back when it leaves the first stage; a write-back to the entry the next instruction
// reads is forwarded, so back-to-back instructions to one entry see the fresh counter.
// Valid marks are flip-flops cleared by reset, so no clearing pass is needed.
// The mode register must only be written while no instruction is in flight.
module branch_history_table_predictor
    import bht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    bht_instr_if.sink    instr,
    bht_result_if.source result
);

    logic [1:0]               mode_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [1:0]               s1_kind_reg;
    idx_t                     s1_idx_reg;
    logic                     s1_taken_reg;
    logic                     fwd_hit_reg;
    logic                     fwd_hit_next;
    ctr_t                     fwd_ctr_reg;
    logic                     last_correct_reg;
    logic                     last_correct_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_correct_reg;
    logic                     out_correct_next;

    logic         in_fire;
    logic         s1_fire;
    idx_t         in_idx;
    logic         in_taken;
    ctr_t         ram_rd_data;
    logic         wr_en;
    bht_upd_in_t  upd_in;
    bht_upd_out_t upd_out;

    assign in_idx   = instr.instr_pc[INDEX_SHIFT +: IDX_W];
    assign in_taken = (instr.instr_kind == KIND_JUMP) || (instr.next_pc == instr.target_addr);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_fire  = instr.valid && instr.ready;

    assign instr.ready    = !s1_valid_reg || s1_fire;
    assign result.valid   = out_valid_reg;
    assign result.pred_ok = out_correct_reg;

    bht_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ctr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (upd_out.ctr_next),
        .rd_en   (in_fire),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        upd_in.mode      = mode_reg;
        upd_in.kind      = s1_kind_reg;
        upd_in.taken     = s1_taken_reg;
        upd_in.hit_valid = valid_reg[s1_idx_reg];
        if (!valid_reg[s1_idx_reg])
        begin
            upd_in.ctr = CTR_STRONG_NOT;
        end
        else if (fwd_hit_reg)
        begin
            upd_in.ctr = fwd_ctr_reg;
        end
        else
        begin
            upd_in.ctr = ram_rd_data;
        end
    end

    bht_update u_update (
        .upd_in  (upd_in),
        .upd_out (upd_out)
    );

    assign wr_en = s1_fire && upd_out.active;

    always_comb
    begin
        valid_next        = valid_reg;
        last_correct_next = last_correct_reg;
        if (wr_en)
        begin
            valid_next[s1_idx_reg] = 1'b1;
            last_correct_next      = upd_out.correct;
        end

        s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);
        fwd_hit_next  = wr_en && (s1_idx_reg == in_idx);

        out_valid_next   = s1_fire || (out_valid_reg && !result.ready);
        out_correct_next = out_correct_reg;
        if (s1_fire)
        begin
            out_correct_next = last_correct_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_OFF;
            valid_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            last_correct_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            valid_reg        <= valid_next;
            s1_valid_reg     <= s1_valid_next;
            last_correct_reg <= last_correct_next;
            out_valid_reg    <= out_valid_next;
            if (in_fire)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= instr.instr_kind;
            s1_idx_reg   <= in_idx;
            s1_taken_reg <= in_taken;
            fwd_ctr_reg  <= upd_out.ctr_next;
        end
        out_correct_reg <= out_correct_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(s1_idx_reg)])
        else $error("Updated entry was not marked valid.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("Finished instruction produced no result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && wr_en && (s1_idx_reg == in_idx)) |=> fwd_hit_reg)
        else $error("Write-back to the entry being read was not forwarded.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (s1_kind_reg == KIND_JUMP) && valid_reg[s1_idx_reg])
            |=> result.pred_ok)
        else $error("Jump on a valid entry was not reported correct.");

endmodule
